>>> rtl/core/epg_pkg.sv
// Shared widths and constants of the ellipse point generator.
`default_nettype none

package epg_pkg;

    // Width of the emitted coordinates (valid range 8 to 16).
    localparam int COORD_BITS = 12;

    // Widths of the configuration registers and the walk state.
    localparam int RAD_W  = 10;
    localparam int SQ_W   = 2 * RAD_W;
    localparam int X_W    = 11;
    localparam int Y_W    = 12;
    localparam int DW     = 48;

    // Sum width for the coordinates: wide enough for center plus offset, then masked.
    localparam int SUM_W  = (COORD_BITS > Y_W + 1) ? COORD_BITS : Y_W + 1;

    // Shared multiplier operand widths (signed).
    localparam int MA_W   = 34;
    localparam int MB_W   = 21;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = RAD_W;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_X = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_Y = 2'd3;

endpackage

`default_nettype wire

>>> rtl/core/epg_mul.sv
// Shared signed multiplier with a registered product.
`default_nettype none

module epg_mul (
    input  wire logic                          clk,
    input  wire logic signed [epg_pkg::MA_W-1:0] a,
    input  wire logic signed [epg_pkg::MB_W-1:0] b,
    output logic signed [epg_pkg::DW-1:0]        prod
);
    import epg_pkg::*;

    logic signed [MA_W+MB_W-1:0] full;
    logic signed [DW-1:0]        prod_reg;

    assign full = a * b;

    // All products of the walk fit the decision width.
    always_ff @(posedge clk)
    begin
        prod_reg <= full[DW-1:0];
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

>>> rtl/core/ellipse_point_generator_unit.sv
// Top level of the midpoint ellipse point generator.
`default_nettype none

// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_ready  restart
// output    out        out_valid/ out_ready valid_res, px_pos, px_neg, py_pos, py_neg, done_res
// config    in         cfg_we (no wait)     cfg_index, cfg_data
//
// A beat without restart runs through the emit state and a sequence of updates through
// the one shared 48-bit adder before the block is ready again. A restart beat first runs
// a setup through the shared multiplier, and the beat on which the walk crosses into
// region two first forms a new decision from three products. A finished walk gives a
// done report. Reset puts the walk in the finished state; there is no clearing pass.
// A stall on the output only holds the sequencer in its emit state.

module ellipse_point_generator_unit (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic                                  restart,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic                                       valid_res,
    output logic signed [epg_pkg::COORD_BITS-1:0]      px_pos,
    output logic signed [epg_pkg::COORD_BITS-1:0]      px_neg,
    output logic signed [epg_pkg::COORD_BITS-1:0]      py_pos,
    output logic signed [epg_pkg::COORD_BITS-1:0]      py_neg,
    output logic                                       done_res,
    input  wire logic                                  cfg_we,
    input  wire logic [epg_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [epg_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import epg_pkg::*;

    typedef enum logic [1:0] {
        REG_ONE,
        REG_TWO,
        REG_DONE
    } region_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RS0,
        S_RS1,
        S_RS2,
        S_RS3,
        S_RS4,
        S_CHECK,
        S_X0,
        S_X1,
        S_X2,
        S_X3,
        S_X4,
        S_X5,
        S_EMIT,
        S_R1_DX,
        S_R1_DY,
        S_R2_DY,
        S_R2_DX,
        S_ADX_END,
        S_ADX,
        S_SDY,
        S_ADD_RY2,
        S_ADD_RX2
    } state_t;

    state_t  state_reg;
    region_t region_reg;

    // Configuration registers.
    logic signed [RAD_W-1:0] center_x_reg;
    logic signed [RAD_W-1:0] center_y_reg;
    logic        [RAD_W-1:0] radius_x_reg;
    logic        [RAD_W-1:0] radius_y_reg;

    // Walk state. Radii are latched at restart so later writes wait for the next one.
    logic        [RAD_W-1:0] ry_reg;
    logic        [SQ_W-1:0]  rx2_reg;
    logic        [SQ_W-1:0]  ry2_reg;
    logic        [X_W-1:0]   x_reg;
    logic signed [Y_W-1:0]   y_reg;
    logic signed [DW-1:0]    d_reg;
    logic signed [DW-1:0]    sdx_reg;
    logic signed [DW-1:0]    sdy_reg;
    logic signed [DW-1:0]    tmp_reg;
    logic                    emit_pt_reg;

    // Output register.
    logic                          out_valid_reg;
    logic                          valid_res_reg;
    logic                          done_res_reg;
    logic signed [COORD_BITS-1:0]  px_pos_reg;
    logic signed [COORD_BITS-1:0]  px_neg_reg;
    logic signed [COORD_BITS-1:0]  py_pos_reg;
    logic signed [COORD_BITS-1:0]  py_neg_reg;

    // Shared multiplier.
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [DW-1:0]   prod;

    // Shared adder / subtractor.
    logic signed [DW-1:0] alu_a;
    logic signed [DW-1:0] alu_b;
    logic                 alu_sub;
    logic signed [DW-1:0] alu_sum;

    logic signed [DW-1:0]   rx2_ext;
    logic signed [DW-1:0]   ry2_ext;
    logic signed [MB_W-1:0] tx_op;
    logic signed [Y_W-1:0]  ty;
    logic signed [MB_W-1:0] ty_op;
    logic                   slope_lt;
    logic                   d_pos;
    logic                   out_free;

    logic signed [SUM_W-1:0] cx_ext;
    logic signed [SUM_W-1:0] cy_ext;
    logic signed [SUM_W-1:0] x_ext;
    logic signed [SUM_W-1:0] y_ext;
    logic signed [SUM_W-1:0] px_pos_sum;
    logic signed [SUM_W-1:0] px_neg_sum;
    logic signed [SUM_W-1:0] py_pos_sum;
    logic signed [SUM_W-1:0] py_neg_sum;

    epg_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign rx2_ext = {{(DW-SQ_W){1'b0}}, rx2_reg};
    assign ry2_ext = {{(DW-SQ_W){1'b0}}, ry2_reg};

    // At the crossing: tx = 2x + 1 (positive) and ty = y - 1 (y is never negative there).
    assign tx_op = {{(MB_W-X_W-1){1'b0}}, x_reg, 1'b1};
    assign ty    = y_reg - Y_W'(1);
    assign ty_op = {{(MB_W-Y_W){ty[Y_W-1]}}, ty};

    assign alu_sum  = alu_a + (alu_sub ? ~alu_b : alu_b) + {{(DW-1){1'b0}}, alu_sub};
    assign slope_lt = alu_sum[DW-1];
    assign d_pos    = !d_reg[DW-1] && (d_reg != '0);
    assign out_free = !out_valid_reg || out_ready;

    // Coordinates of the current offset, wrapped to the coordinate width.
    assign cx_ext     = {{(SUM_W-RAD_W){center_x_reg[RAD_W-1]}}, center_x_reg};
    assign cy_ext     = {{(SUM_W-RAD_W){center_y_reg[RAD_W-1]}}, center_y_reg};
    assign x_ext      = {{(SUM_W-X_W){1'b0}}, x_reg};
    assign y_ext      = {{(SUM_W-Y_W){y_reg[Y_W-1]}}, y_reg};
    assign px_pos_sum = cx_ext + x_ext;
    assign px_neg_sum = cx_ext - x_ext;
    assign py_pos_sum = cy_ext + y_ext;
    assign py_neg_sum = cy_ext - y_ext;

    // Multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_RS0:
            begin
                mul_a = {{(MA_W-RAD_W){1'b0}}, radius_x_reg};
                mul_b = {{(MB_W-RAD_W){1'b0}}, radius_x_reg};
            end
            S_RS1:
            begin
                mul_a = {{(MA_W-RAD_W){1'b0}}, ry_reg};
                mul_b = {{(MB_W-RAD_W){1'b0}}, ry_reg};
            end
            S_RS2:
            begin
                mul_a = {{(MA_W-SQ_W){1'b0}}, rx2_reg};
                mul_b = {{(MB_W-RAD_W){1'b0}}, ry_reg};
            end
            S_X0:
            begin
                mul_a = {{(MA_W-SQ_W){1'b0}}, ry2_reg};
                mul_b = tx_op;
            end
            S_X1:
            begin
                mul_a = prod[MA_W-1:0];
                mul_b = tx_op;
            end
            S_X2:
            begin
                mul_a = {{(MA_W-SQ_W){1'b0}}, rx2_reg};
                mul_b = ty_op;
            end
            S_X3:
            begin
                mul_a = prod[MA_W-1:0];
                mul_b = ty_op;
            end
            S_X4:
            begin
                mul_a = {{(MA_W-SQ_W){1'b0}}, rx2_reg};
                mul_b = {{(MB_W-SQ_W){1'b0}}, ry2_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Adder operand selection: one add or subtract per cycle.
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            S_CHECK:
            begin
                alu_a   = sdx_reg;
                alu_b   = sdy_reg;
                alu_sub = 1'b1;
            end
            S_RS3:
            begin
                alu_a = ry2_ext <<< 2;
                alu_b = rx2_ext;
            end
            S_RS4:
            begin
                alu_a   = d_reg;
                alu_b   = tmp_reg <<< 2;
                alu_sub = 1'b1;
            end
            S_X4:
            begin
                alu_a = tmp_reg;
                alu_b = prod <<< 2;
            end
            S_X5:
            begin
                alu_a   = d_reg;
                alu_b   = prod <<< 2;
                alu_sub = 1'b1;
            end
            S_R1_DX, S_R2_DX:
            begin
                alu_a = sdx_reg;
                alu_b = ry2_ext <<< 1;
            end
            S_R1_DY, S_R2_DY:
            begin
                alu_a   = sdy_reg;
                alu_b   = rx2_ext <<< 1;
                alu_sub = 1'b1;
            end
            S_ADX_END, S_ADX:
            begin
                alu_a = d_reg;
                alu_b = sdx_reg <<< 2;
            end
            S_SDY:
            begin
                alu_a   = d_reg;
                alu_b   = sdy_reg <<< 2;
                alu_sub = 1'b1;
            end
            S_ADD_RY2:
            begin
                alu_a = d_reg;
                alu_b = ry2_ext <<< 2;
            end
            S_ADD_RX2:
            begin
                alu_a = d_reg;
                alu_b = rx2_ext <<< 2;
            end
            default:
            begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    // Sequencer, walk state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            region_reg    <= REG_DONE;
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            radius_x_reg  <= '0;
            radius_y_reg  <= '0;
            ry_reg        <= '0;
            rx2_reg       <= '0;
            ry2_reg       <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            d_reg         <= '0;
            sdx_reg       <= '0;
            sdy_reg       <= '0;
            tmp_reg       <= '0;
            emit_pt_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_res_reg <= 1'b0;
            done_res_reg  <= 1'b0;
            px_pos_reg    <= '0;
            px_neg_reg    <= '0;
            py_pos_reg    <= '0;
            py_neg_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CENTER_X: center_x_reg <= cfg_data;
                    CFG_CENTER_Y: center_y_reg <= cfg_data;
                    CFG_RADIUS_X: radius_x_reg <= cfg_data;
                    CFG_RADIUS_Y: radius_y_reg <= cfg_data;
                    default:      center_x_reg <= center_x_reg;
                endcase
            end

            // The emit state loads a new beat itself when the old one leaves.
            if (out_valid_reg && out_ready && (state_reg != S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= restart ? S_RS0 : S_CHECK;
                    end
                end

                // Restart: latch the radii and form the squares and the first decision.
                S_RS0:
                begin
                    ry_reg     <= radius_y_reg;
                    x_reg      <= '0;
                    y_reg      <= {{(Y_W-RAD_W){1'b0}}, radius_y_reg};
                    sdx_reg    <= '0;
                    region_reg <= REG_ONE;
                    state_reg  <= S_RS1;
                end
                S_RS1:
                begin
                    rx2_reg   <= prod[SQ_W-1:0];
                    state_reg <= S_RS2;
                end
                S_RS2:
                begin
                    ry2_reg   <= prod[SQ_W-1:0];
                    state_reg <= S_RS3;
                end
                S_RS3:
                begin
                    sdy_reg   <= prod <<< 1;
                    tmp_reg   <= prod;
                    d_reg     <= alu_sum;
                    state_reg <= S_RS4;
                end
                S_RS4:
                begin
                    d_reg     <= alu_sum;
                    state_reg <= S_CHECK;
                end

                // Decide what this beat gives: a point, the crossing, or the done flag.
                S_CHECK:
                begin
                    case (region_reg)
                        REG_ONE:
                        begin
                            if (slope_lt)
                            begin
                                emit_pt_reg <= 1'b1;
                                state_reg   <= S_EMIT;
                            end
                            else
                            begin
                                state_reg <= S_X0;
                            end
                        end
                        REG_TWO:
                        begin
                            if (y_reg[Y_W-1])
                            begin
                                region_reg  <= REG_DONE;
                                emit_pt_reg <= 1'b0;
                            end
                            else
                            begin
                                emit_pt_reg <= 1'b1;
                            end
                            state_reg <= S_EMIT;
                        end
                        default:
                        begin
                            emit_pt_reg <= 1'b0;
                            state_reg   <= S_EMIT;
                        end
                    endcase
                end

                // Crossing into region two: d2 from three products.
                S_X0: state_reg <= S_X1;
                S_X1: state_reg <= S_X2;
                S_X2:
                begin
                    tmp_reg   <= prod;
                    state_reg <= S_X3;
                end
                S_X3: state_reg <= S_X4;
                S_X4:
                begin
                    d_reg     <= alu_sum;
                    state_reg <= S_X5;
                end
                S_X5:
                begin
                    d_reg      <= alu_sum;
                    region_reg <= REG_TWO;
                    state_reg  <= S_CHECK;
                end

                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        valid_res_reg <= emit_pt_reg;
                        done_res_reg  <= !emit_pt_reg;
                        if (emit_pt_reg)
                        begin
                            px_pos_reg <= px_pos_sum[COORD_BITS-1:0];
                            px_neg_reg <= px_neg_sum[COORD_BITS-1:0];
                            py_pos_reg <= py_pos_sum[COORD_BITS-1:0];
                            py_neg_reg <= py_neg_sum[COORD_BITS-1:0];
                            state_reg  <= (region_reg == REG_ONE) ? S_R1_DX : S_R2_DY;
                        end
                        else
                        begin
                            px_pos_reg <= '0;
                            px_neg_reg <= '0;
                            py_pos_reg <= '0;
                            py_neg_reg <= '0;
                            state_reg  <= S_IDLE;
                        end
                    end
                end

                // Region one: x always steps; y steps when the decision is not negative.
                S_R1_DX:
                begin
                    x_reg     <= x_reg + X_W'(1);
                    sdx_reg   <= alu_sum;
                    state_reg <= d_reg[DW-1] ? S_ADX_END : S_R1_DY;
                end
                S_R1_DY:
                begin
                    y_reg     <= y_reg - Y_W'(1);
                    sdy_reg   <= alu_sum;
                    state_reg <= S_ADX;
                end

                // Region two: y always steps; x steps when the decision is not positive.
                S_R2_DY:
                begin
                    y_reg     <= y_reg - Y_W'(1);
                    sdy_reg   <= alu_sum;
                    state_reg <= d_pos ? S_SDY : S_R2_DX;
                end
                S_R2_DX:
                begin
                    x_reg     <= x_reg + X_W'(1);
                    sdx_reg   <= alu_sum;
                    state_reg <= S_ADX;
                end

                // Decision update terms, one per cycle.
                S_ADX_END:
                begin
                    d_reg     <= alu_sum;
                    state_reg <= S_ADD_RY2;
                end
                S_ADX:
                begin
                    d_reg     <= alu_sum;
                    state_reg <= S_SDY;
                end
                S_SDY:
                begin
                    d_reg     <= alu_sum;
                    state_reg <= (region_reg == REG_ONE) ? S_ADD_RY2 : S_ADD_RX2;
                end
                S_ADD_RY2, S_ADD_RX2:
                begin
                    d_reg     <= alu_sum;
                    state_reg <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign valid_res = valid_res_reg;
    assign done_res  = done_res_reg;
    assign px_pos    = px_pos_reg;
    assign px_neg    = px_neg_reg;
    assign py_pos    = py_pos_reg;
    assign py_neg    = py_neg_reg;

endmodule

`default_nettype wire

>>> dv/ellipse_point_generator_unit_test.sv
// Self-checking testbench of the ellipse point generator with its own walk predictor.
module ellipse_point_generator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import epg_pkg::*;

    // The run is ended by the cycle counter if the block ever stops answering.
    localparam int CYCLE_LIMIT = 1_000_000;
    // Input beats to plan before the stimulus stops.
    localparam int BEAT_TARGET = 1550;
    // Length of each long output hold-off, in clock cycles.
    localparam int HOLD_CYCLES = 300;
    // Only the first few mismatches are printed; all of them are counted.
    localparam int MAX_PRINTED = 40;

    // Register values at the edges of their ranges.
    localparam logic [CFG_DATA_W-1:0] CENTER_MIN = 10'h200;
    localparam logic [CFG_DATA_W-1:0] CENTER_MAX = 10'h1FF;
    localparam logic [CFG_DATA_W-1:0] RADIUS_MAX = 10'h3FF;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // One result beat: the four mirrored coordinates and the two flags.
    typedef struct packed {
        logic   valid_res;
        coord_t px_pos;
        coord_t px_neg;
        coord_t py_pos;
        coord_t py_neg;
        logic   done_res;
    } point_set_t;

    // Region one steps x, region two steps y.
    typedef enum logic [1:0] {
        STEP_X,
        STEP_Y,
        WALK_DONE
    } walk_region_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  restart = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  valid_res;
    coord_t                px_pos;
    coord_t                px_neg;
    coord_t                py_pos;
    coord_t                py_neg;
    logic                  done_res;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    ellipse_point_generator_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .restart   (restart),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .valid_res (valid_res),
        .px_pos    (px_pos),
        .px_neg    (px_neg),
        .py_pos    (py_pos),
        .py_neg    (py_neg),
        .done_res  (done_res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Copy of the configuration registers as the block holds them.
    longint cfg_center_x = 0;
    longint cfg_center_y = 0;
    longint cfg_radius_x = 0;
    longint cfg_radius_y = 0;

    // Walk state of the predictor. Decision values are scaled by four, so they stay exact.
    longint       walk_x = 0;
    longint       walk_y = 0;
    longint       walk_decision = 0;
    longint       walk_slope_dx = 0;
    longint       walk_slope_dy = 0;
    longint       walk_rx = 0;
    longint       walk_ry = 0;
    walk_region_t walk_region = WALK_DONE;

    // Restart bits waiting to be offered, and point sets waiting to come out.
    bit         pending_restarts[$];
    point_set_t point_sets_due[$];
    point_set_t next_set;
    point_set_t want;

    int  planned_beats = 0;
    int  beats_in = 0;
    int  restart_beats = 0;
    int  sets_out = 0;
    int  done_reports = 0;
    int  mismatches = 0;
    int  send_gap = 0;
    int  recv_stall = 0;
    int  cycle_count = 0;
    bit  quiet_phase = 1'b0;
    bit  hold_off = 1'b0;

    initial begin
        forever #5 clk = ~clk;
    end

    // Gap lengths: mostly short, sometimes medium, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 94)
            return $urandom_range(4, 12);
        return $urandom_range(25, 80);
    endfunction

    // Works out the point set that one accepted beat produces and advances the walk.
    // A restart loads the radii from the registers; the centre is always read live.
    function automatic point_set_t step_ellipse_walk(input logic restart_bit);
        point_set_t ps;
        longint     rx_sq;
        longint     ry_sq;
        longint     tx;
        longint     ty;
        ps = '0;
        if (restart_bit) begin
            walk_rx       = cfg_radius_x;
            walk_ry       = cfg_radius_y;
            rx_sq         = walk_rx * walk_rx;
            ry_sq         = walk_ry * walk_ry;
            walk_x        = 0;
            walk_y        = walk_ry;
            walk_decision = 4 * ry_sq - 4 * rx_sq * walk_ry + rx_sq;
            walk_slope_dx = 0;
            walk_slope_dy = 2 * rx_sq * walk_ry;
            walk_region   = STEP_X;
        end
        rx_sq = walk_rx * walk_rx;
        ry_sq = walk_ry * walk_ry;

        // Crossing into region two: the decision value is rebuilt at the current point.
        if (walk_region == STEP_X && !(walk_slope_dx < walk_slope_dy)) begin
            tx            = 2 * walk_x + 1;
            ty            = walk_y - 1;
            walk_decision = ry_sq * tx * tx + 4 * rx_sq * ty * ty - 4 * rx_sq * ry_sq;
            walk_region   = STEP_Y;
        end
        if (walk_region == STEP_Y && walk_y < 0)
            walk_region = WALK_DONE;

        // Nothing left to plot: a done report with zero coordinates, state untouched.
        if (walk_region == WALK_DONE) begin
            ps.done_res = 1'b1;
            return ps;
        end

        ps.valid_res = 1'b1;
        ps.px_pos    = coord_t'(cfg_center_x + walk_x);
        ps.px_neg    = coord_t'(cfg_center_x - walk_x);
        ps.py_pos    = coord_t'(cfg_center_y + walk_y);
        ps.py_neg    = coord_t'(cfg_center_y - walk_y);

        if (walk_region == STEP_X) begin
            walk_x++;
            walk_slope_dx += 2 * ry_sq;
            if (walk_decision < 0) begin
                walk_decision += 4 * walk_slope_dx + 4 * ry_sq;
            end else begin
                walk_y--;
                walk_slope_dy -= 2 * rx_sq;
                walk_decision += 4 * (walk_slope_dx - walk_slope_dy) + 4 * ry_sq;
            end
        end else begin
            walk_y--;
            walk_slope_dy -= 2 * rx_sq;
            if (walk_decision > 0) begin
                walk_decision += 4 * rx_sq - 4 * walk_slope_dy;
            end else begin
                walk_x++;
                walk_slope_dx += 2 * ry_sq;
                walk_decision += 4 * (walk_slope_dx - walk_slope_dy) + 4 * rx_sq;
            end
        end
        return ps;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint exp_val);
        if (mismatches < MAX_PRINTED)
            $display("MISMATCH at point set %0d: %s: got %0d, expected %0d",
                     sets_out, what, got, exp_val);
        mismatches++;
    endtask

    // Sender. The payload only changes once the current beat has been taken, and the
    // predictor runs on the very edge at which the block accepts a beat.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                next_set = step_ellipse_walk(restart);
                point_sets_due.push_back(next_set);
                beats_in <= beats_in + 1;
                if (restart)
                    restart_beats <= restart_beats + 1;
            end
            if (!in_valid || in_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end else if (pending_restarts.size() != 0) begin
                    in_valid <= 1'b1;
                    restart  <= pending_restarts.pop_front();
                    if (!quiet_phase && $urandom_range(0, 99) < 30)
                        send_gap <= idle_len();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver. Every point set that is taken is compared with the oldest prediction.
    // Ready drops at random, and stays low for the whole of a long hold-off.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                sets_out <= sets_out + 1;
                if (done_res)
                    done_reports <= done_reports + 1;
                if (point_sets_due.size() == 0) begin
                    report_mismatch("point set with no beat waiting", 0, 0);
                end else begin
                    want = point_sets_due.pop_front();
                    if (valid_res !== want.valid_res)
                        report_mismatch("valid_res", valid_res, want.valid_res);
                    if (px_pos !== want.px_pos)
                        report_mismatch("px_pos", longint'(px_pos), longint'(want.px_pos));
                    if (px_neg !== want.px_neg)
                        report_mismatch("px_neg", longint'(px_neg), longint'(want.px_neg));
                    if (py_pos !== want.py_pos)
                        report_mismatch("py_pos", longint'(py_pos), longint'(want.py_pos));
                    if (py_neg !== want.py_neg)
                        report_mismatch("py_neg", longint'(py_neg), longint'(want.py_neg));
                    if (done_res !== want.done_res)
                        report_mismatch("done_res", done_res, want.done_res);
                end
            end
            if (hold_off) begin
                out_ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall <= recv_stall - 1;
                out_ready  <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 99) < 20) begin
                recv_stall <= idle_len();
                out_ready  <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Two long hold-offs on the output while the sender still has beats queued, so the
    // block backs up and has to drop in_ready.
    initial begin
        for (int k = 0; k < 2; k++) begin
            while (!(beats_in >= 300 + 600 * k && pending_restarts.size() > 8))
                @(negedge clk);
            @(posedge clk);
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_off <= 1'b0;
        end
    end

    // Watchdog: the run may never take longer than this.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[ellipse_point_generator_unit] ERROR");
        $finish;
    end

    // Main sequence: reset, a directed part, random phases, then drain and decide.
    initial begin
        int                    kind;
        int                    span;
        logic [CFG_DATA_W-1:0] rx;
        logic [CFG_DATA_W-1:0] ry;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Straight out of reset the walk is finished, so an advance gets a done report.
        // A restart on the reset registers then plots the single point at the origin.
        queue_beat(1'b0);
        queue_walk(1);

        // No horizontal radius: region one is skipped and a vertical line comes out.
        wait_idle();
        load_config(CENTER_MIN, CENTER_MAX, '0, 10'd3, 4'hF);
        queue_walk(4);

        // No vertical radius: only the centre offset comes out before done.
        wait_idle();
        load_config(CENTER_MAX, CENTER_MIN, 10'd5, '0, 4'hF);
        queue_walk(2);

        // Widest ellipse: the largest products in the decision arithmetic.
        wait_idle();
        load_config(CENTER_MIN, CENTER_MIN, RADIUS_MAX, RADIUS_MAX, 4'hF);
        queue_walk(4);

        // A small complete walk through both regions, past its last point into done.
        wait_idle();
        load_config(CENTER_MAX, CENTER_MAX, 10'd4, 10'd2, 4'hF);
        queue_walk(8);

        // Random phases. Most are complete walks over small ellipses; big ones are cut
        // short. Some rewrite registers halfway through a walk and carry on, and the
        // rest are loose mixes of restarts and advances.
        while (planned_beats < BEAT_TARGET) begin
            wait_idle();
            quiet_phase = ($urandom_range(0, 9) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                rx = pick_radius();
                ry = pick_radius();
                load_config(pick_center(), pick_center(), rx, ry, 4'hF);
                span = int'(rx) + int'(ry);
                if (span > 120)
                    queue_walk($urandom_range(20, 120));
                else
                    queue_walk(span + $urandom_range(1, 4));
            end else if (kind < 84) begin
                // New radii written here must wait for the next restart to matter.
                load_config(pick_center(), pick_center(), pick_radius(), pick_radius(),
                            4'($urandom_range(1, 15)));
                repeat ($urandom_range(1, 40)) queue_beat(1'b0);
            end else begin
                repeat ($urandom_range(5, 30)) queue_beat($urandom_range(0, 3) == 0);
            end
        end

        wait_idle();
        quiet_phase = 1'b0;
        repeat (20) @(posedge clk);
        if (point_sets_due.size() != 0)
            report_mismatch("point sets never delivered", point_sets_due.size(), 0);

        $display("Covered %0d input beats (%0d restarts) and %0d point sets, %0d of them done",
                 beats_in, restart_beats, sets_out, done_reports);
        $display("reports, under random gaps, long output hold-offs and live register rewrites.");
        if (mismatches == 0)
            $display("[ellipse_point_generator_unit] OK");
        else
            $display("[ellipse_point_generator_unit] ERROR");
        $finish;
    end

    task automatic queue_beat(input bit restart_bit);
        pending_restarts.push_back(restart_bit);
        planned_beats++;
    endtask

    // A restart followed by a number of advance beats.
    task automatic queue_walk(input int advances);
        queue_beat(1'b1);
        repeat (advances) queue_beat(1'b0);
    endtask

    // Idle means nothing queued, nothing offered, nothing outstanding and the block ready.
    task automatic wait_idle();
        @(negedge clk);
        while (pending_restarts.size() != 0 || in_valid || !in_ready
               || point_sets_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_CENTER_X: cfg_center_x = longint'($signed(data));
            CFG_CENTER_Y: cfg_center_y = longint'($signed(data));
            CFG_RADIUS_X: cfg_radius_x = longint'(data);
            CFG_RADIUS_Y: cfg_radius_y = longint'(data);
            default: ;
        endcase
    endtask

    // Writes the registers selected by the mask on consecutive cycles.
    task automatic load_config(input logic [CFG_DATA_W-1:0] cx, input logic [CFG_DATA_W-1:0] cy,
                               input logic [CFG_DATA_W-1:0] rx, input logic [CFG_DATA_W-1:0] ry,
                               input logic [3:0] mask);
        if (mask[0])
            write_reg(CFG_CENTER_X, cx);
        if (mask[1])
            write_reg(CFG_CENTER_Y, cy);
        if (mask[2])
            write_reg(CFG_RADIUS_X, rx);
        if (mask[3])
            write_reg(CFG_RADIUS_Y, ry);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly small radii so walks finish quickly; a few large ones, the maximum included.
    function automatic logic [CFG_DATA_W-1:0] pick_radius();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 70)
            return CFG_DATA_W'($urandom_range(1, 20));
        if (r < 90)
            return CFG_DATA_W'($urandom_range(21, 60));
        if (r < 96)
            return CFG_DATA_W'($urandom_range(61, 900));
        if (r < 98)
            return RADIUS_MAX;
        return CFG_DATA_W'($urandom_range(901, 1023));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_center();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return CENTER_MIN;
        if (r < 16)
            return CENTER_MAX;
        return CFG_DATA_W'($urandom_range(0, 1023));
    endfunction

endmodule
